FILE: hdl/bam_pkg.sv
// Package for the binned average map: shared constants and the item kind type.
// Used by bam_store and binned_average_map.
package bam_pkg;
  localparam int MAX_DIMS_DEF = 2;
  localparam int MAX_BINS_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int SUM_WIDTH_DEF = 40;
  localparam int IDX_W = 12;
  localparam int DEPTH = 4096;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_READ = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  localparam logic [2:0] REG_DIMS = 3'd0;
  localparam logic [2:0] REG_BINS0 = 3'd1;
  localparam logic [2:0] REG_BINS1 = 3'd2;
  localparam logic [2:0] REG_LO0 = 3'd3;
  localparam logic [2:0] REG_LO1 = 3'd4;
  localparam logic [2:0] REG_HI0 = 3'd5;
  localparam logic [2:0] REG_HI1 = 3'd6;
endpackage

FILE: hdl/bam_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on nothing but its parameter; used by binned_average_map.
module bam_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W + 1);
  logic [CW-1:0] steps;
  logic [W-1:0] dsr;
  logic [W:0] trial;
  logic running;

  assign trial = {remainder, quotient[W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
      steps <= '0;
    end else if (go) begin
      running <= 1'b1;
      steps <= CW'(W);
      quotient <= dividend;
      remainder <= '0;
      dsr <= divisor;
    end else if (running) begin
      if (trial[W]) begin
        remainder <= {remainder[W-2:0], quotient[W-1]};
        quotient <= {quotient[W-2:0], 1'b0};
      end else begin
        remainder <= trial[W-1:0];
        quotient <= {quotient[W-2:0], 1'b1};
      end
      steps <= steps - 1'b1;
      if (steps == CW'(1)) begin
        running <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

FILE: hdl/bam_store.sv
// Per-bin count and sum memory with a clearing sweep after reset.
// Depends on bam_pkg; used by binned_average_map.
module bam_store #(
  parameter int COUNT_WIDTH = bam_pkg::COUNT_WIDTH_DEF,
  parameter int SUM_WIDTH = bam_pkg::SUM_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bam_pkg::IDX_W-1:0]     rd_addr,
  output logic [COUNT_WIDTH-1:0]        rd_count,
  output logic signed [SUM_WIDTH-1:0]   rd_sum,
  input  logic                          wr_en,
  input  logic [bam_pkg::IDX_W-1:0]     wr_addr,
  input  logic [COUNT_WIDTH-1:0]        wr_count,
  input  logic signed [SUM_WIDTH-1:0]   wr_sum,
  output logic                          ready
);
  logic [COUNT_WIDTH-1:0] count_mem [bam_pkg::DEPTH];
  logic [SUM_WIDTH-1:0] sum_mem [bam_pkg::DEPTH];
  logic [bam_pkg::IDX_W:0] sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      ready <= 1'b0;
    end else if (!ready) begin
      sweep <= sweep + 1'b1;
      if (sweep[bam_pkg::IDX_W-1:0] == '1) ready <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      count_mem[sweep[bam_pkg::IDX_W-1:0]] <= '0;
      sum_mem[sweep[bam_pkg::IDX_W-1:0]] <= '0;
    end else if (wr_en) begin
      count_mem[wr_addr] <= wr_count;
      sum_mem[wr_addr] <= wr_sum;
    end
    rd_count <= count_mem[rd_addr];
    rd_sum <= sum_mem[rd_addr];
  end
endmodule

FILE: hdl/binned_average_map.sv
// Binned average map: one item at a time, result strobed once, busy high while working.
// An add divides once per coordinate in use on the shared serial divider (a clamped coordinate
// skips its division); a read of a filled bin runs an integer and a fraction division on it,
// while a clear or an empty read does not divide; DIV_W is SUM_WIDTH+9. The next word is
// taken at the edge ending the strobe cycle. After reset a clearing sweep of the store holds busy.
module binned_average_map #(
  parameter int MAX_DIMS = bam_pkg::MAX_DIMS_DEF,
  parameter int MAX_BINS_PER_DIM = bam_pkg::MAX_BINS_DEF,
  parameter int COUNT_WIDTH = bam_pkg::COUNT_WIDTH_DEF,
  parameter int SUM_WIDTH = bam_pkg::SUM_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [15:0] coord_0,
  input  logic signed [15:0] coord_1,
  input  logic signed [15:0] sample_value,
  input  logic [11:0]        bin_select,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               strobe,
  output logic [11:0]        bin_index,
  output logic signed [23:0] average_q8,
  output logic [23:0]        sample_count,
  output logic               empty_res,
  output logic               dropped
);
  localparam int DIV_W = SUM_WIDTH + 9;
  localparam int BW = $clog2(MAX_BINS_PER_DIM + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV0, S_WAIT0, S_DIV1, S_WAIT1, S_ADDR, S_RD, S_UPD,
    S_DIVA, S_WAITA, S_DIVF, S_WAITF, S_OUT
  } state_t;
  state_t state;

  logic [1:0] dims;
  logic [6:0] bins0, bins1;
  logic signed [15:0] lo0, lo1, hi0, hi1;

  logic [1:0] kind_r;
  logic signed [15:0] c0, c1, val;
  logic [11:0] idx;
  logic [BW-1:0] b0, b1;
  logic drop_r;
  logic [DIV_W-1:0] qhi;
  logic neg;

  logic div_go, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q, div_r;
  logic [DIV_W-1:0] dv_a_next, dv_b_next;

  logic st_ready, wr_en;
  logic [COUNT_WIDTH-1:0] rd_count, wr_count;
  logic signed [SUM_WIDTH-1:0] rd_sum, wr_sum;

  bam_div #(.W(DIV_W)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  bam_store #(.COUNT_WIDTH(COUNT_WIDTH), .SUM_WIDTH(SUM_WIDTH)) u_store (
    .clk(clk), .rst(rst), .rd_addr(idx), .rd_count(rd_count), .rd_sum(rd_sum),
    .wr_en(wr_en), .wr_addr(idx), .wr_count(wr_count), .wr_sum(wr_sum),
    .ready(st_ready)
  );

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE) || !st_ready;

  function automatic logic [BW-1:0] clampb(input logic [6:0] b);
    if (b == 7'd0) return BW'(1);
    if (32'(b) > MAX_BINS_PER_DIM) return BW'(MAX_BINS_PER_DIM);
    return BW'(b);
  endfunction

  logic [BW-1:0] nb0, nb1;
  assign nb0 = clampb(bins0);
  assign nb1 = clampb(bins1);
  logic use2;
  assign use2 = (MAX_DIMS >= 2) && (dims[1] == 1'b1);

  // Clamp test and division operands for the coordinate in flight.
  logic sel1;
  logic signed [15:0] cc, cl, ch;
  logic [BW-1:0] cb;
  logic signed [17:0] diffc, diffr;
  logic below, above;
  assign sel1 = (state == S_DIV1);
  assign cc = sel1 ? c1 : c0;
  assign cl = sel1 ? lo1 : lo0;
  assign ch = sel1 ? hi1 : hi0;
  assign cb = sel1 ? nb1 : nb0;
  assign below = cc <= cl;
  assign above = cc >= ch;
  assign diffc = 18'(cc) - 18'(cl);
  assign diffr = 18'(ch) - 18'(cl);

  // Magnitude of the sum and saturated add.
  logic [SUM_WIDTH-1:0] mag;
  logic signed [SUM_WIDTH:0] ssum;
  localparam logic signed [SUM_WIDTH:0] SMAX = (SUM_WIDTH + 1)'({1'b0, {(SUM_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_WIDTH:0] SMIN = -SMAX - 1;
  assign mag = rd_sum[SUM_WIDTH-1] ? SUM_WIDTH'(-rd_sum) : SUM_WIDTH'(rd_sum);
  assign ssum = (SUM_WIDTH + 1)'(rd_sum) + (SUM_WIDTH + 1)'(val);

  logic [BW-1:0] q_bin;
  logic [11:0] idx2;
  assign q_bin = div_q[BW-1:0];
  assign idx2 = use2 ? 12'(32'(b0) + 32'(nb0) * 32'(b1)) : 12'(b0);

  logic [23:0] lim;
  logic [DIV_W-1:0] mfull;
  assign lim = neg ? 24'h800000 : 24'h7FFFFF;
  assign mfull = {qhi[DIV_W-9:0], 8'd0} + div_q;

  logic [23:0] cnt_sat;
  assign cnt_sat = (COUNT_WIDTH > 24 && (rd_count >> 24) != 0) ? 24'hFFFFFF
                   : 24'(rd_count);

  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [23:0] inc_sat;
  assign cnt_inc = rd_count + 1'b1;
  assign inc_sat = (COUNT_WIDTH > 24 && (cnt_inc >> 24) != 0) ? 24'hFFFFFF
                   : 24'(cnt_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= 2'd2;
      bins0 <= 7'd16;
      bins1 <= 7'd16;
      lo0 <= '0;
      lo1 <= '0;
      hi0 <= 16'sd32767;
      hi1 <= 16'sd32767;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bam_pkg::REG_DIMS: dims <= cfg_data[1:0];
        bam_pkg::REG_BINS0: bins0 <= cfg_data[6:0];
        bam_pkg::REG_BINS1: bins1 <= cfg_data[6:0];
        bam_pkg::REG_LO0: lo0 <= cfg_data;
        bam_pkg::REG_LO1: lo1 <= cfg_data;
        bam_pkg::REG_HI0: hi0 <= cfg_data;
        bam_pkg::REG_HI1: hi1 <= cfg_data;
        default: ;
      endcase
    end
  end

  // The offset is below 2^16 and the bin count at most MAX_BINS_PER_DIM whenever a division runs.
  logic [23:0] prod;
  always_comb begin
    prod = 24'(diffc[16:0]) * 24'(cb - 1'b1);
    dv_a_next = DIV_W'(prod);
    dv_b_next = DIV_W'(diffr);
  end

  always_ff @(posedge clk) begin
    div_go <= 1'b0;
    wr_en <= 1'b0;
    strobe <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (start && st_ready) begin
          kind_r <= kind;
          c0 <= coord_0;
          c1 <= coord_1;
          val <= sample_value;
          idx <= bin_select;
          drop_r <= 1'b0;
          state <= (kind == bam_pkg::KIND_ADD) ? S_DIV0 : S_RD;
        end
        S_DIV0, S_DIV1: begin
          div_a <= dv_a_next;
          div_b <= dv_b_next;
          div_go <= !(below || above);
          if (below || above) begin
            if (state == S_DIV0) b0 <= below ? '0 : nb0 - 1'b1;
            else b1 <= below ? '0 : nb1 - 1'b1;
            state <= (state == S_DIV0) ? (use2 ? S_DIV1 : S_ADDR) : S_ADDR;
          end else begin
            state <= (state == S_DIV0) ? S_WAIT0 : S_WAIT1;
          end
        end
        S_WAIT0: if (div_done) begin
          b0 <= q_bin;
          state <= use2 ? S_DIV1 : S_ADDR;
        end
        S_WAIT1: if (div_done) begin
          b1 <= q_bin;
          state <= S_ADDR;
        end
        S_ADDR: begin
          idx <= idx2;
          state <= S_RD;
        end
        S_RD: state <= S_UPD;
        S_UPD: begin
          average_q8 <= '0;
          neg <= rd_sum[SUM_WIDTH-1];
          priority case (kind_r)
            bam_pkg::KIND_ADD: begin
              if (rd_count == '1) begin
                drop_r <= 1'b1;
                sample_count <= cnt_sat;
                empty_res <= 1'b0;
                state <= S_OUT;
              end else begin
                wr_en <= 1'b1;
                wr_count <= cnt_inc;
                wr_sum <= (ssum > SMAX) ? SUM_WIDTH'(SMAX) :
                          (ssum < SMIN) ? SUM_WIDTH'(SMIN) : SUM_WIDTH'(ssum);
                sample_count <= inc_sat;
                empty_res <= 1'b0;
                state <= S_OUT;
                drop_r <= 1'b0;
              end
            end
            bam_pkg::KIND_CLEAR: begin
              wr_en <= 1'b1;
              wr_count <= '0;
              wr_sum <= '0;
              sample_count <= '0;
              empty_res <= 1'b1;
              state <= S_OUT;
            end
            default: begin
              sample_count <= cnt_sat;
              empty_res <= (rd_count == '0);
              if (rd_count == '0) begin
                state <= S_OUT;
              end else begin
                div_a <= DIV_W'(mag);
                div_b <= DIV_W'(rd_count);
                state <= S_DIVA;
              end
            end
          endcase
        end
        S_DIVA: begin
          div_go <= 1'b1;
          state <= S_WAITA;
        end
        S_WAITA: if (div_done) begin
          qhi <= div_q;
          div_a <= {div_r[DIV_W-9:0], 8'd0};
          state <= S_DIVF;
        end
        S_DIVF: begin
          div_go <= 1'b1;
          state <= S_WAITF;
        end
        S_WAITF: if (div_done) begin
          // The negative limit pattern already reads as the most negative value.
          if ((qhi >> 24) != 0 || mfull > DIV_W'(lim))
            average_q8 <= $signed(lim);
          else
            average_q8 <= neg ? -$signed(mfull[23:0]) : $signed(mfull[23:0]);
          state <= S_OUT;
        end
        S_OUT: begin
          strobe <= 1'b1;
          bin_index <= idx;
          dropped <= drop_r;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
